FILE: hdl/wpce_pkg.sv
// Shared types, codes and constants for the wrap-aware pulse count extender.
`default_nettype none

package wpce_pkg;

   // Width of the free-running pulse counter that is sampled (8 to 32).
   localparam int SAMPLE_BITS = 16;
   localparam int RAW_BITS    = 16;
   localparam int ACC_BITS    = 64;

   typedef enum logic [2:0] {
      REQ_SAMPLE    = 3'd0,
      REQ_RESET     = 3'd1,
      REQ_LOAD      = 3'd2,
      REQ_START     = 3'd3,
      REQ_STOP      = 3'd4,
      REQ_CLEAR_OVF = 3'd5,
      REQ_ARM       = 3'd6
   } req_code_type;

   typedef enum logic [2:0] {
      CSR_ENABLE    = 3'd0,
      CSR_DIRECTION = 3'd1,
      CSR_WIDTH     = 3'd2,
      CSR_START     = 3'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      WIDTH_8  = 2'd0,
      WIDTH_16 = 2'd1,
      WIDTH_32 = 2'd2,
      WIDTH_64 = 2'd3
   } width_sel_type;

   typedef struct packed {
      logic                enable;
      logic                direction;
      width_sel_type       width;
      logic [ACC_BITS-1:0] start;
   } cfg_type;

   // All-ones mask of the selected overflow width.
   function automatic logic [ACC_BITS-1:0] width_mask(input width_sel_type sel);
      logic [ACC_BITS-1:0] mask;
      case (sel)
         WIDTH_8:  mask = {{(ACC_BITS-8){1'b0}},  {8{1'b1}}};
         WIDTH_16: mask = {{(ACC_BITS-16){1'b0}}, {16{1'b1}}};
         WIDTH_32: mask = {{(ACC_BITS-32){1'b0}}, {32{1'b1}}};
         default:  mask = {ACC_BITS{1'b1}};
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/wrap_aware_pulse_count_extender.sv
// Top level: transaction handshakes, configuration registers and counter core.
//
//   channel | direction | handshake              | payload
//   req_    | in        | req_valid / req_stall  | req_type, req_raw_count, req_new_value
//   rsp_    | out       | rsp_valid / rsp_stall  | rsp_count_value, rsp_overflow_seen
//   csr_    | in        | csr_valid / csr_ready  | csr_index, csr_data
//
// Each transaction passes through the input register and then updates the
// counter state, which is the result. One transaction per cycle is
// sustained while the result is not stalled; the 64-bit add/compare on the
// accumulator sets the clock period.
// Reset (synchronous, active high) empties both stages and loads register
// defaults. A stalled result holds the input stage; only then is req_stall high.
`default_nettype none

module wrap_aware_pulse_count_extender
   import wpce_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [2:0]          req_type,
   input  wire logic [RAW_BITS-1:0] req_raw_count,
   input  wire logic [ACC_BITS-1:0] req_new_value,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [ACC_BITS-1:0]      rsp_count_value,
   output logic                     rsp_overflow_seen,

   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [ACC_BITS-1:0] csr_data
);

   // Input stage.
   logic                in_valid_ff, in_valid_in;
   logic [2:0]          type_ff;
   logic [RAW_BITS-1:0] raw_ff;
   logic [ACC_BITS-1:0] new_ff;

   // Result stage: valid flag here, payload is the counter state itself.
   logic rsp_valid_ff, rsp_valid_in;

   cfg_type cfg_ff, cfg_in;

   logic out_free;
   logic advance;

   // The result slot is free when empty or being taken this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = out_free ? advance : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the payload whenever the input stage is open.
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         type_ff <= req_type;
         raw_ff  <= req_raw_count;
         new_ff  <= req_new_value;
      end
   end

   // Configuration: always ready; writes beyond the register list drop.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ENABLE:    cfg_in.enable    = csr_data[0];
            CSR_DIRECTION: cfg_in.direction = csr_data[0];
            CSR_WIDTH:     cfg_in.width     = width_sel_type'(csr_data[1:0]);
            CSR_START:     cfg_in.start     = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.direction <= 1'b0;
         cfg_ff.width     <= WIDTH_64;
         cfg_ff.start     <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Counter state advances exactly when the result slot loads, so it
   // doubles as the result payload and holds while the result is stalled.
   wpce_core u_core (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_type      (type_ff),
      .raw_count     (raw_ff),
      .new_value     (new_ff),
      .cfg           (cfg_ff),
      .count_value   (rsp_count_value),
      .overflow_seen (rsp_overflow_seen)
   );

   assign rsp_valid = rsp_valid_ff;

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("held transaction lost from input stage");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced transaction produced no result");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room downstream");

endmodule

`default_nettype wire

FILE: hdl/wpce_core.sv
// Counter state and the per-transaction update of the accumulator.
`default_nettype none

module wpce_core
   import wpce_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [2:0]             req_type,
   input  wire logic [RAW_BITS-1:0]    raw_count,
   input  wire logic [ACC_BITS-1:0]    new_value,
   input  wire cfg_type                cfg,
   output logic      [ACC_BITS-1:0]    count_value,
   output logic                        overflow_seen
);

   logic [ACC_BITS-1:0]    acc_ff, acc_in;
   logic [SAMPLE_BITS-1:0] prev_ff, prev_in;
   logic                   ovf_ff, ovf_in;
   logic                   active_ff, active_in;

   logic [SAMPLE_BITS+RAW_BITS-1:0] raw_ext;
   logic [SAMPLE_BITS-1:0]          cur;
   logic [SAMPLE_BITS-1:0]          step;
   logic [ACC_BITS-1:0]             step_ext;
   logic [ACC_BITS:0]               sum;
   logic [ACC_BITS-1:0]             counted;
   logic                            carry;
   logic                            too_wide;
   logic [ACC_BITS-1:0]             mask;

   // Keep only the low sample bits; the wrapped difference is the step.
   assign raw_ext  = {{SAMPLE_BITS{1'b0}}, raw_count};
   assign cur      = raw_ext[SAMPLE_BITS-1:0];
   assign step     = cur - prev_ff;
   assign step_ext = {{(ACC_BITS-SAMPLE_BITS){1'b0}}, step};
   assign sum      = {1'b0, acc_ff} + {1'b0, step_ext};
   assign mask     = width_mask(cfg.width);

   always_comb begin
      carry = 1'b0;
      if (cfg.direction) begin
         counted = (acc_ff >= step_ext) ? (acc_ff - step_ext) : acc_ff;
      end else begin
         counted = sum[ACC_BITS-1:0];
         carry   = sum[ACC_BITS];
      end
      too_wide = carry || ((counted & ~mask) != '0);
   end

   always_comb begin
      acc_in    = acc_ff;
      prev_in   = prev_ff;
      ovf_in    = ovf_ff;
      active_in = active_ff;
      if (advance) begin
         case (req_code_type'(req_type))
            REQ_SAMPLE: begin
               if (cfg.enable && active_ff) begin
                  prev_in = cur;
                  if (too_wide) begin
                     acc_in = cfg.start & mask;
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = counted;
                  end
               end
            end
            REQ_RESET: begin
               acc_in    = cfg.start;
               ovf_in    = 1'b0;
               prev_in   = '0;
               active_in = 1'b1;
            end
            REQ_LOAD: begin
               acc_in  = new_value;
               prev_in = '0;
            end
            REQ_START:     active_in = 1'b1;
            REQ_STOP:      active_in = 1'b0;
            REQ_CLEAR_OVF: ovf_in    = 1'b0;
            REQ_ARM: begin
               acc_in    = cfg.start;
               prev_in   = '0;
               active_in = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         prev_ff   <= '0;
         ovf_ff    <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         acc_ff    <= acc_in;
         prev_ff   <= prev_in;
         ovf_ff    <= ovf_in;
         active_ff <= active_in;
      end
   end

   assign count_value   = acc_ff;
   assign overflow_seen = ovf_ff;

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(acc_ff) && $stable(ovf_ff) && $stable(prev_ff))
      else $error("counter state moved without a transaction");

   a_load: assert property (@(posedge clock) disable iff (reset)
      advance && req_type == REQ_LOAD |=> acc_ff == $past(new_value) && prev_ff == '0)
      else $error("load did not take the new value");

   a_clear_ovf: assert property (@(posedge clock) disable iff (reset)
      advance && (req_type == REQ_CLEAR_OVF || req_type == REQ_RESET) |=> !ovf_ff)
      else $error("overflow flag not cleared");

   a_overflow_in_range: assert property (@(posedge clock) disable iff (reset)
      advance && req_type == REQ_SAMPLE && $rose(ovf_ff) == 1'b0 && too_wide
         && cfg.enable && active_ff |=> ovf_ff && ((acc_ff & ~$past(mask)) == '0))
      else $error("overflow reload left value beyond selected width");

endmodule

`default_nettype wire

FILE: dv/wrap_aware_pulse_count_extender_test.sv
// Self-checking testbench for the wrap-aware pulse count extender.

module wrap_aware_pulse_count_extender_test;
   import wpce_pkg::*;

   // Request code the block must ignore; it reports its state unchanged.
   localparam logic [2:0] REQ_UNUSED = 3'd7;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 155;

   // Keeps its own copy of the counter state and registers, predicts one
   // result per accepted transaction and matches results in order.
   class scoreboard_type;
      logic                enable;
      logic                direction;
      width_sel_type       width;
      logic [ACC_BITS-1:0] start;
      logic [ACC_BITS-1:0] acc;
      logic [SAMPLE_BITS-1:0] prev;
      logic                ovf;
      logic                active;
      logic [ACC_BITS-1:0] want_count[$];
      logic                want_overflow[$];
      int                  mismatches;

      function new();
         enable     = 1'b0;
         direction  = 1'b0;
         width      = WIDTH_64;
         start      = '0;
         acc        = '0;
         prev       = '0;
         ovf        = 1'b0;
         active     = 1'b0;
         mismatches = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [ACC_BITS-1:0] data);
         case (idx)
            CSR_ENABLE:    enable = data[0];
            CSR_DIRECTION: direction = data[0];
            CSR_WIDTH:     width = width_sel_type'(data[1:0]);
            CSR_START:     start = data;
            default: ;
         endcase
      endfunction

      function logic [ACC_BITS-1:0] width_limit();
         case (width)
            WIDTH_8:  return 64'h0000_0000_0000_00FF;
            WIDTH_16: return 64'h0000_0000_0000_FFFF;
            WIDTH_32: return 64'h0000_0000_FFFF_FFFF;
            default:  return 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
      endfunction

      function void fold_sample(logic [SAMPLE_BITS-1:0] cur);
         logic [SAMPLE_BITS-1:0] step;
         logic [ACC_BITS:0]      sum;
         logic [ACC_BITS-1:0]    limit;
         logic                   over;
         step  = cur - prev;
         limit = width_limit();
         over  = 1'b0;
         if (direction) begin
            if (acc >= step) acc = acc - step;
         end else begin
            sum  = {1'b0, acc} + step;
            over = sum[ACC_BITS];
            acc  = sum[ACC_BITS-1:0];
         end
         prev = cur;
         if (over || acc > limit) begin
            acc = start & limit;
            ovf = 1'b1;
         end
      endfunction

      function void note_request(logic [2:0] code, logic [RAW_BITS-1:0] raw,
                                 logic [ACC_BITS-1:0] value);
         case (code)
            REQ_SAMPLE: if (enable && active) fold_sample(raw[SAMPLE_BITS-1:0]);
            REQ_RESET: begin
               acc    = start;
               ovf    = 1'b0;
               prev   = '0;
               active = 1'b1;
            end
            REQ_LOAD: begin
               acc  = value;
               prev = '0;
            end
            REQ_START:     active = 1'b1;
            REQ_STOP:      active = 1'b0;
            REQ_CLEAR_OVF: ovf = 1'b0;
            REQ_ARM: begin
               acc    = start;
               prev   = '0;
               active = 1'b1;
            end
            default: ;
         endcase
         want_count.push_back(acc);
         want_overflow.push_back(ovf);
      endfunction

      function int pending();
         return want_count.size();
      endfunction

      task report(string msg);
         mismatches++;
         $display("error: %s", msg);
      endtask

      task check_result(logic [ACC_BITS-1:0] count, logic overflow);
         logic [ACC_BITS-1:0] c;
         logic                o;
         if (want_count.size() == 0) begin
            report($sformatf("result with nothing outstanding: count %h overflow %b",
                             count, overflow));
            return;
         end
         c = want_count.pop_front();
         o = want_overflow.pop_front();
         if (count !== c) report($sformatf("count_value %h, predicted %h", count, c));
         if (overflow !== o)
            report($sformatf("overflow_seen %b, predicted %b", overflow, o));
      endtask

      task close_out();
         if (want_count.size() != 0)
            report($sformatf("%0d results never arrived", want_count.size()));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [2:0]          req_type;
   logic [RAW_BITS-1:0] req_raw_count;
   logic [ACC_BITS-1:0] req_new_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ACC_BITS-1:0] rsp_count_value;
   logic                rsp_overflow_seen;
   logic                csr_valid;
   logic                csr_ready;
   logic [2:0]          csr_index;
   logic [ACC_BITS-1:0] csr_data;

   // High during phases that run flat out, with no gaps and no stalls.
   bit                  calm;
   // Model of the free-running pulse counter that the samples come from.
   logic [RAW_BITS-1:0] free_count;

   scoreboard_type sb = new();

   wrap_aware_pulse_count_extender DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_raw_count     (req_raw_count),
      .req_new_value     (req_new_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_count_value   (rsp_count_value),
      .rsp_overflow_seen (rsp_overflow_seen),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop: far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Check every result transaction as it is taken at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_count_value, rsp_overflow_seen);
   end

   // Result side: draw a stall before each transaction, hold it, then release
   // and wait for the transaction to go through.
   initial begin
      int hold;
      rsp_stall = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 5);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall = 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   // Present one request transaction after a random gap and hold it until it
   // is taken. Valid stays high on return so back-to-back items need no drop.
   task send_request(input logic [2:0] code, input logic [RAW_BITS-1:0] raw,
                     input logic [ACC_BITS-1:0] value);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = code;
      req_raw_count = raw;
      req_new_value = value;
      do @(posedge clock); while (req_stall);
      sb.note_request(code, raw, value);
      @(negedge clock);
   endtask

   // Write one configuration register; only called with the block idle.
   task write_reg(input csr_index_type idx, input logic [ACC_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Drop valid, wait for every outstanding result, then let the two-stage
   // pipe settle before returning on a falling edge.
   task drain();
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // One random transaction: mostly samples of a counter that moves forward
   // by a plausible amount, with commands and the odd wild jump mixed in.
   task random_item();
      int                  pick;
      logic [ACC_BITS-1:0] value;
      logic [RAW_BITS-1:0] raw;
      pick  = $urandom_range(0, 99);
      value = {$urandom, $urandom};
      raw   = RAW_BITS'($urandom);
      if (pick < 70) begin
         case ($urandom_range(0, 9))
            0: free_count = RAW_BITS'($urandom);
            1: ; // repeat the last reading: zero step
            default: free_count = RAW_BITS'(free_count + $urandom_range(0, 400));
         endcase
         send_request(REQ_SAMPLE, free_count, value);
      end else if (pick < 74) begin
         send_request(REQ_RESET, raw, value);
      end else if (pick < 80) begin
         // Bias loads towards the width limit so overflow is reached often.
         case ($urandom_range(0, 2))
            0: ;
            1: value = sb.width_limit() - $urandom_range(0, 600);
            default: value = ACC_BITS'($urandom_range(0, 1000));
         endcase
         send_request(REQ_LOAD, raw, value);
      end else if (pick < 85) begin
         send_request(REQ_START, raw, value);
      end else if (pick < 89) begin
         send_request(REQ_STOP, raw, value);
      end else if (pick < 94) begin
         send_request(REQ_CLEAR_OVF, raw, value);
      end else if (pick < 98) begin
         send_request(REQ_ARM, raw, value);
      end else begin
         send_request(REQ_UNUSED, raw, value);
      end
   endtask

   initial begin
      int                  p;
      int                  i;
      logic [ACC_BITS-1:0] seed_value;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_SAMPLE;
      req_raw_count = '0;
      req_new_value = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_ENABLE;
      csr_data      = '0;
      calm          = 1'b0;
      free_count    = '0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults: channel disabled, so samples change nothing; an
      // unused code is ignored as well.
      send_request(REQ_SAMPLE, 16'hFFFF, '0);
      send_request(REQ_UNUSED, '0, '0);
      send_request(REQ_START, '0, '0);
      send_request(REQ_SAMPLE, 16'h1234, '1);

      // Count up at full width from just below the 64-bit maximum.
      drain();
      write_reg(CSR_ENABLE, 64'd1);
      write_reg(CSR_DIRECTION, 64'd0);
      write_reg(CSR_WIDTH, 64'(WIDTH_64));
      write_reg(CSR_START, 64'hFFFF_FFFF_FFFF_FFF0);
      send_request(REQ_RESET, '0, '0);
      send_request(REQ_SAMPLE, 16'h0010, '0);  // carry out of 64 bits
      send_request(REQ_CLEAR_OVF, '0, '0);
      send_request(REQ_LOAD, '0, '1);
      send_request(REQ_SAMPLE, 16'h0000, '0);  // zero step at the maximum
      send_request(REQ_SAMPLE, 16'h0001, '0);  // carry again
      send_request(REQ_STOP, '0, '0);
      send_request(REQ_SAMPLE, 16'h8000, '0);  // stopped: no change
      send_request(REQ_START, '0, '0);
      send_request(REQ_SAMPLE, 16'hFFFF, '0);
      send_request(REQ_SAMPLE, 16'h0000, '0);  // counter wraps round
      send_request(REQ_ARM, '0, '0);           // overflow flag is kept
      send_request(REQ_LOAD, '1, '0);
      send_request(REQ_UNUSED, '1, '1);

      // Count down at 8 bits with a start value wider than the mask.
      drain();
      write_reg(CSR_WIDTH, 64'(WIDTH_8));
      write_reg(CSR_DIRECTION, 64'd1);
      write_reg(CSR_START, 64'h1FF);
      send_request(REQ_LOAD, '0, 64'd5);
      send_request(REQ_SAMPLE, 16'd3, '0);
      send_request(REQ_SAMPLE, 16'd7, '0);     // step larger than the count
      send_request(REQ_SAMPLE, 16'd7, '0);
      send_request(REQ_LOAD, '0, 64'h100);
      send_request(REQ_SAMPLE, 16'd0, '0);     // zero step, already over
      send_request(REQ_RESET, '0, '0);
      send_request(REQ_SAMPLE, 16'd0, '0);     // unmasked start is over
      send_request(REQ_LOAD, '0, '1);
      send_request(REQ_SAMPLE, 16'hFFFF, '0);

      // Random phases, each with its own settings; every register is
      // rewritten with the block idle.
      for (p = 0; p < PHASES; p++) begin
         drain();
         case (p % 4)
            0: seed_value = {$urandom, $urandom};
            1: seed_value = '0;
            2: seed_value = '1;
            default: seed_value = ACC_BITS'($urandom_range(0, 1023));
         endcase
         write_reg(CSR_ENABLE, (p == 5) ? 64'd0 : 64'd1);
         write_reg(CSR_DIRECTION, (p % 3 == 1) ? 64'd1 : 64'd0);
         write_reg(CSR_WIDTH, 64'(p % 4));
         write_reg(CSR_START, seed_value);
         calm = (p == 3 || p == 7);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            // Hold off halfway through until the pipe is empty.
            if (i == PHASE_ITEMS / 2) drain();
            random_item();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      sb.close_out();
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
